FILE: design/tpr_pkg.sv
// Shared types and constants of the typed packet receiver.
package tpr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ENTRY_W    = 13;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned PAYLOAD_W  = 32;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned BUILTIN_LEN = 4;

  // Fields of one type table entry.
  localparam int unsigned ENT_ID_LSB   = 0;
  localparam int unsigned ENT_LEN_LSB  = 8;
  localparam int unsigned ENT_CRIT_BIT = 11;
  localparam int unsigned ENT_EN_BIT   = 12;

  // Built-in type bytes and the expected packet byte sum.
  localparam logic [7:0] TYPE_CONNECT = 8'h00;
  localparam logic [7:0] TYPE_CONNACK = 8'h01;
  localparam logic [7:0] TYPE_ACK     = 8'h02;
  localparam logic [7:0] SUM_GOOD     = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CONNECT = 3'd1,
    ST_CONNACK = 3'd2,
    ST_ACK     = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_BADSUM  = 3'd5,
    ST_DUP     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CSUM  = 2'd1,
    OP_ID    = 2'd2,
    OP_DATA  = 2'd3
  } op_kind_e;

  // One classified byte, handed from the front to the back.
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       last;
    logic       crit;
    logic       builtin;
    status_e    imm_status;
    logic [7:0] id_quot;
  } tpr_op_t;

endpackage

FILE: design/tpr_front.sv
// Front end: type table, packet phase tracking and byte classification.
module tpr_front #(
  parameter int unsigned NUM_TYPES   = 4,
  parameter int unsigned ID_SLOTS    = 10,
  parameter int unsigned MAX_PAYLOAD = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpr_pkg::ENTRY_W-1:0]     cfg_data_i,
  input  logic                            byte_fire_i,
  input  logic [7:0]                      byte_i,
  output tpr_pkg::tpr_op_t                op_o
);

  // Reciprocal for the id slot quotient; exact for every byte value.
  localparam int unsigned RECIP = (65536 + ID_SLOTS - 1) / ID_SLOTS;

  typedef enum logic [3:0] {
    PH_TYPE = 4'b0001,
    PH_CSUM = 4'b0010,
    PH_ID   = 4'b0100,
    PH_DATA = 4'b1000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [tpr_pkg::ENTRY_W-1:0] tab_q [NUM_TYPES];
  logic [tpr_pkg::ENTRY_W-1:0] tab_d [NUM_TYPES];
  logic [2:0] len_q, len_d;
  logic [2:0] cnt_q, cnt_d;
  logic       crit_q, crit_d;

  logic       hit;
  logic [2:0] hit_len;
  logic       hit_crit;
  logic [2:0] raw_len;
  logic [24:0] quot_prod;

  always_comb begin
    for (int i = 0; i < NUM_TYPES; i++) begin
      tab_d[i] = tab_q[i];
      if (cfg_we_i && cfg_index_i == tpr_pkg::CFG_IDX_W'(i)) begin
        tab_d[i] = cfg_data_i;
      end
    end
  end

  // Lowest enabled matching entry wins.
  always_comb begin
    hit      = 1'b0;
    hit_len  = '0;
    hit_crit = 1'b0;
    raw_len  = '0;
    for (int i = NUM_TYPES - 1; i >= 0; i--) begin
      if (tab_q[i][tpr_pkg::ENT_EN_BIT] &&
          tab_q[i][tpr_pkg::ENT_ID_LSB +: 8] == byte_i) begin
        hit      = 1'b1;
        raw_len  = tab_q[i][tpr_pkg::ENT_LEN_LSB +: 3];
        hit_crit = tab_q[i][tpr_pkg::ENT_CRIT_BIT];
      end
    end
    hit_len = (raw_len > 3'(MAX_PAYLOAD)) ? 3'(MAX_PAYLOAD) : raw_len;
  end

  assign quot_prod = {17'b0, byte_i} * 25'(RECIP);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crit_d  = crit_q;
    op_o.kind       = tpr_pkg::OP_START;
    op_o.data       = byte_i;
    op_o.last       = 1'b0;
    op_o.crit       = crit_q;
    op_o.builtin    = 1'b0;
    op_o.imm_status = tpr_pkg::ST_OK;
    op_o.id_quot    = quot_prod[16 +: 8];
    unique case (phase_q)
      PH_TYPE: begin
        op_o.kind = tpr_pkg::OP_START;
        cnt_d     = '0;
        if (byte_i == tpr_pkg::TYPE_ACK) begin
          op_o.last       = 1'b1;
          op_o.crit       = 1'b0;
          op_o.imm_status = tpr_pkg::ST_ACK;
        end else if (byte_i == tpr_pkg::TYPE_CONNECT || byte_i == tpr_pkg::TYPE_CONNACK) begin
          op_o.builtin = 1'b1;
          op_o.crit    = 1'b0;
          crit_d       = 1'b0;
          len_d        = 3'(tpr_pkg::BUILTIN_LEN);
          phase_d      = PH_CSUM;
        end else if (hit) begin
          op_o.crit = hit_crit;
          crit_d    = hit_crit;
          len_d     = hit_len;
          phase_d   = PH_CSUM;
        end else begin
          op_o.last       = 1'b1;
          op_o.crit       = 1'b0;
          op_o.imm_status = tpr_pkg::ST_UNKNOWN;
        end
      end
      PH_CSUM: begin
        op_o.kind = tpr_pkg::OP_CSUM;
        if (crit_q) begin
          phase_d = PH_ID;
        end else if (len_q == '0) begin
          op_o.last = 1'b1;
          phase_d   = PH_TYPE;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_ID: begin
        op_o.kind = tpr_pkg::OP_ID;
        if (len_q == '0) begin
          op_o.last = 1'b1;
          phase_d   = PH_TYPE;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        op_o.kind = tpr_pkg::OP_DATA;
        cnt_d     = cnt_q + 3'd1;
        if (cnt_d >= len_q) begin
          op_o.last = 1'b1;
          phase_d   = PH_TYPE;
        end
      end
      default: begin
        phase_d = PH_TYPE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      len_q   <= '0;
      cnt_q   <= '0;
      crit_q  <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        tab_q[i] <= '0;
      end
    end else begin
      tab_q <= tab_d;
      if (byte_fire_i) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        crit_q  <= crit_d;
      end
    end
  end

endmodule

FILE: design/tpr_fifo.sv
// Two-entry queue of classified bytes between front and back.
module tpr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  tpr_pkg::tpr_op_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output tpr_pkg::tpr_op_t pop_data_o
);

  tpr_pkg::tpr_op_t slots_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/tpr_back.sv
// Back end: checksum, id table, payload assembly and the result register.
module tpr_back #(
  parameter int unsigned ID_SLOTS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  output logic             op_ready_o,
  input  tpr_pkg::tpr_op_t op_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       type_id_o,
  output logic [7:0]       packet_id_o,
  output logic [31:0]      payload_o,
  output logic [2:0]       payload_len_o
);

  localparam int unsigned SLOT_W = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;

  // Id table: a memory plus one valid bit per slot; an invalid slot reads as zero.
  logic [7:0]          ids_mem [ID_SLOTS];
  logic [ID_SLOTS-1:0] ids_vld_q;

  logic [16:0]       slot_prod;
  logic [16:0]       slot_diff;
  logic [SLOT_W-1:0] slot_a;
  logic              pop;

  logic              b_valid_q;
  tpr_pkg::tpr_op_t  b_op_q;
  logic [7:0]        rd_id_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_slot_q;
  logic              b_fire;

  logic [7:0]        sum_q, sum_d;
  logic [31:0]       pay_q, pay_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [7:0]        id_q, id_d;
  logic              dup_q, dup_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [7:0]        type_q, type_d;
  logic              crit_q, crit_d;
  logic              builtin_q, builtin_d;

  tpr_pkg::status_e  fin_status;
  logic              fin_connect;
  logic              fin_record;
  logic              sum_ok;
  logic              finish;

  logic              out_valid_q;
  tpr_pkg::status_e  out_status_q;
  logic [7:0]        out_type_q;
  logic [7:0]        out_id_q;
  logic [31:0]       out_pay_q;
  logic [2:0]        out_len_q;

  // Slot of an id byte: remainder from the quotient the front worked out.
  assign slot_prod = {9'b0, op_i.id_quot} * 17'(ID_SLOTS);
  assign slot_diff = {9'b0, op_i.data} - slot_prod;
  assign slot_a    = slot_diff[SLOT_W-1:0];

  assign b_fire     = b_valid_q && (!b_op_q.last || !out_valid_q || res_ready_i);
  assign op_ready_o = !b_valid_q || b_fire;
  assign pop        = op_valid_i && op_ready_o;
  assign finish     = b_fire && b_op_q.last;

  always_comb begin
    sum_d     = sum_q;
    pay_d     = pay_q;
    cnt_d     = cnt_q;
    id_d      = id_q;
    dup_d     = dup_q;
    slot_d    = slot_q;
    type_d    = type_q;
    crit_d    = crit_q;
    builtin_d = builtin_q;
    unique case (b_op_q.kind)
      tpr_pkg::OP_START: begin
        sum_d     = b_op_q.data;
        type_d    = b_op_q.data;
        crit_d    = b_op_q.crit;
        builtin_d = b_op_q.builtin;
        pay_d     = '0;
        cnt_d     = '0;
        id_d      = '0;
        dup_d     = 1'b0;
      end
      tpr_pkg::OP_CSUM: begin
        sum_d = sum_q + b_op_q.data;
      end
      tpr_pkg::OP_ID: begin
        sum_d  = sum_q + b_op_q.data;
        id_d   = b_op_q.data;
        dup_d  = ((rd_vld_q ? rd_id_q : 8'h00) == b_op_q.data);
        slot_d = rd_slot_q;
      end
      tpr_pkg::OP_DATA: begin
        sum_d = sum_q + b_op_q.data;
        if (cnt_q < 3'd4) begin
          pay_d = pay_q | ({24'b0, b_op_q.data} << {cnt_q[1:0], 3'b000});
        end
        cnt_d = cnt_q + 3'd1;
      end
    endcase
  end

  assign sum_ok = (sum_d == tpr_pkg::SUM_GOOD);

  always_comb begin
    fin_status  = tpr_pkg::ST_OK;
    fin_connect = 1'b0;
    fin_record  = 1'b0;
    if (b_op_q.kind == tpr_pkg::OP_START) begin
      fin_status = b_op_q.imm_status;
    end else if (builtin_d) begin
      if (!sum_ok) begin
        fin_status = tpr_pkg::ST_BADSUM;
      end else if (type_d == tpr_pkg::TYPE_CONNECT) begin
        fin_status  = tpr_pkg::ST_CONNECT;
        fin_connect = 1'b1;
      end else begin
        fin_status = tpr_pkg::ST_CONNACK;
      end
    end else if (dup_d) begin
      fin_status = tpr_pkg::ST_DUP;
    end else if (!sum_ok) begin
      fin_status = tpr_pkg::ST_BADSUM;
    end else begin
      fin_status = tpr_pkg::ST_OK;
      fin_record = crit_d;
    end
  end

  // Memory port: one write at the end of an accepted critical packet, one
  // registered read whenever a byte enters the back stage.
  always_ff @(posedge clk_i) begin
    if (finish && fin_record) begin
      ids_mem[slot_d] <= id_d;
    end
    if (pop) begin
      rd_id_q <= ids_mem[slot_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_op_q <= op_i;
    end
    if (finish) begin
      out_status_q <= fin_status;
      out_type_q   <= type_d;
      out_id_q     <= crit_d ? id_d : 8'h00;
      out_pay_q    <= pay_d;
      out_len_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_slot_q   <= '0;
      ids_vld_q   <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      pay_q       <= '0;
      cnt_q       <= '0;
      id_q        <= '0;
      dup_q       <= 1'b0;
      slot_q      <= '0;
      type_q      <= '0;
      crit_q      <= 1'b0;
      builtin_q   <= 1'b0;
    end else begin
      if (op_ready_o) begin
        b_valid_q <= op_valid_i;
      end
      if (pop) begin
        rd_vld_q  <= ids_vld_q[slot_a];
        rd_slot_q <= slot_a;
      end
      if (finish && fin_connect) begin
        ids_vld_q <= '0;
      end else if (finish && fin_record) begin
        ids_vld_q[slot_d] <= 1'b1;
      end
      if (b_fire) begin
        sum_q     <= sum_d;
        pay_q     <= pay_d;
        cnt_q     <= cnt_d;
        id_q      <= id_d;
        dup_q     <= dup_d;
        slot_q    <= slot_d;
        type_q    <= type_d;
        crit_q    <= crit_d;
        builtin_q <= builtin_d;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign type_id_o     = out_type_q;
  assign packet_id_o   = out_id_q;
  assign payload_o     = out_pay_q;
  assign payload_len_o = out_len_q;

  // A connect that completes leaves every id slot empty.
  a_connect_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && fin_connect) |=> (ids_vld_q == '0))
    else $error("id table not cleared after connect");

  // A recorded id marks at least one slot as filled.
  a_record_sets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && fin_record) |=> ($countones(ids_vld_q) != 0))
    else $error("recorded id left no valid slot");

  // A waiting result is never overwritten by a finishing packet.
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |=> (out_valid_q && $stable(out_status_q)
                                       && $stable(out_pay_q)))
    else $error("pending result overwritten");

  // A finishing byte never advances while its result cannot be stored.
  a_no_lost_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_op_q.last && out_valid_q && !res_ready_i) |=> b_valid_q)
    else $error("finishing byte dropped under back pressure");

endmodule

FILE: design/typed_packet_receiver_core.sv
// Top level of the typed packet receiver: front, queue and back joined.
//
//   Channel  Direction  Handshake                 Content
//   rx       in         rx_valid_i / rx_ready_o   rx_byte_i
//   result   out        res_valid_o / res_ready_i status, type id, packet id, payload
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while rx_ready_o is high. A byte is classified in the
// front in the cycle it is accepted, waits in a two-entry queue, and is then
// carried out in the back stage, whose id table is a memory with one write
// port and a registered read port. A result appears on the result channel
// from an output register, in which it waits until it is taken.
// Reset clears the type table, the id table valid bits and all packet state;
// there is no clearing pass. When the result register is full and not taken,
// only finishing bytes stall; the queue then fills and rx_ready_o drops.
// Configuration writes are taken in every cycle.
module typed_packet_receiver_core #(
  parameter int unsigned NUM_TYPES   = 4,
  parameter int unsigned ID_SLOTS    = 10,
  parameter int unsigned MAX_PAYLOAD = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    type_id_o,
  output logic [7:0]                    packet_id_o,
  output logic [31:0]                   payload_o,
  output logic [2:0]                    payload_len_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tpr_pkg::ENTRY_W-1:0]   cfg_data_i
);

  tpr_pkg::tpr_op_t front_op;
  tpr_pkg::tpr_op_t queue_op;
  logic             rx_fire;
  logic             queue_valid;
  logic             queue_ready;

  // The type table takes a write request in any cycle.
  assign cfg_ready_o = 1'b1;
  assign rx_fire     = rx_valid_i && rx_ready_o;

  tpr_front #(
    .NUM_TYPES  (NUM_TYPES),
    .ID_SLOTS   (ID_SLOTS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .byte_fire_i(rx_fire),
    .byte_i     (rx_byte_i),
    .op_o       (front_op)
  );

  // The queue lets the front keep taking bytes while the back waits on the
  // result channel.
  tpr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(rx_valid_i),
    .push_ready_o(rx_ready_o),
    .push_data_i (front_op),
    .pop_valid_o (queue_valid),
    .pop_ready_i (queue_ready),
    .pop_data_o  (queue_op)
  );

  tpr_back #(
    .ID_SLOTS(ID_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (queue_valid),
    .op_ready_o   (queue_ready),
    .op_i         (queue_op),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .status_o     (status_o),
    .type_id_o    (type_id_o),
    .packet_id_o  (packet_id_o),
    .payload_o    (payload_o),
    .payload_len_o(payload_len_o)
  );

endmodule

FILE: dv/typed_packet_receiver_core_tb.sv
// Self-checking testbench for the typed packet receiver core.
module typed_packet_receiver_core_tb;

  localparam int NUM_TYPES      = 4;
  localparam int ID_SLOTS       = 10;
  localparam int MAX_PAYLOAD    = 4;
  localparam int CLK_PERIOD     = 12;
  // Extra cycles after the last result, to let bytes in the queue and the back stage clear.
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_BYTES    = 125;
  localparam int TIMEOUT_CYCLES = 200000;

  // Register indexes of the type table; anything at or above NUM_TYPES is ignored.
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] TYPE_ENTRY_0 = 4'd0;
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] TYPE_ENTRY_1 = 4'd1;
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] TYPE_ENTRY_2 = 4'd2;
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] TYPE_ENTRY_3 = 4'd3;
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = 4'hF;

  typedef enum logic [1:0] {RX_TYPE, RX_SUM, RX_ID, RX_DATA} rx_stage_e;

  typedef struct {
    tpr_pkg::status_e status;
    logic [7:0]       type_id;
    logic [7:0]       packet_id;
    logic [31:0]      payload;
    logic [2:0]       payload_len;
  } rx_result_t;

  // One byte of the directed sequence. Where typed is set, the packet outcome
  // is obvious from the bytes and is written here; otherwise the predictor decides.
  typedef struct {
    logic [7:0]       rx;
    bit               typed;
    tpr_pkg::status_e status;
    logic [7:0]       type_id;
    logic [7:0]       packet_id;
    logic [31:0]      payload;
    logic [2:0]       payload_len;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 34;

  // The directed table runs against this register setting:
  //   entry 0: type 0xFF, disabled   entry 1: type 0x10, plain, no payload
  //   entry 2: type 0x20, critical, no payload
  //   entry 3: type 0x30, critical, length field 7 (clamped to four bytes)
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // Acknowledge is answered on its own byte.
    '{8'h02, 1'b1, tpr_pkg::ST_ACK,     8'h02, 8'h00, 32'h0, 3'd0},
    // The only entry for 0xFF is disabled, and the out-of-range writes must not alias.
    '{8'hFF, 1'b1, tpr_pkg::ST_UNKNOWN, 8'hFF, 8'h00, 32'h0, 3'd0},
    // Id 0 matches an empty slot, so it is a duplicate although the sum is good.
    '{8'h20, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hDF, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h00, 1'b1, tpr_pkg::ST_DUP,     8'h20, 8'h00, 32'h0, 3'd0},
    // Id 0x0D is accepted and recorded, then refused the second time.
    '{8'h20, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hD2, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h0D, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h20, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hD2, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h0D, 1'b1, tpr_pkg::ST_DUP,     8'h20, 8'h0D, 32'h0, 3'd0},
    // A good connect clears the id table.
    '{8'h00, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h55, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h11, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h22, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h33, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h44, 1'b1, tpr_pkg::ST_CONNECT, 8'h00, 8'h00, 32'h44332211, 3'd4},
    // So the same id goes through again.
    '{8'h20, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hD2, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h0D, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    // A plain type without payload ends on its checksum byte, good and bad.
    '{8'h10, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hEF, 1'b1, tpr_pkg::ST_OK,      8'h10, 8'h00, 32'h0, 3'd0},
    '{8'h10, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h00, 1'b1, tpr_pkg::ST_BADSUM,  8'h10, 8'h00, 32'h0, 3'd0},
    // Length field 7 is clamped to four payload bytes, with both byte extremes.
    '{8'h30, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hBA, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h17, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h00, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'hFF, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h80, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h7F, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    // This packet is left open on purpose: the next register setting rewrites
    // entry 3, and the rest of the packet must keep the length latched here.
    '{8'h30, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h5C, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0},
    '{8'h21, 1'b0, tpr_pkg::ST_OK,      8'h00, 8'h00, 32'h0, 3'd0}
  };

  // Ports of the block; every input has a known value from time zero.
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          rx_valid_i  = 1'b0;
  logic                          rx_ready_o;
  logic [7:0]                    rx_byte_i   = 8'h00;
  logic                          res_valid_o;
  logic                          res_ready_i = 1'b0;
  logic [2:0]                    status_o;
  logic [7:0]                    type_id_o;
  logic [7:0]                    packet_id_o;
  logic [31:0]                   payload_o;
  logic [2:0]                    payload_len_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tpr_pkg::ENTRY_W-1:0]   cfg_data_i  = '0;

  // Predictor state: the register copy, the packet being assembled and the
  // table of accepted critical ids.
  logic [tpr_pkg::ENTRY_W-1:0] type_table [NUM_TYPES] = '{default: '0};
  logic [7:0]         seen_ids [ID_SLOTS]    = '{default: 8'h00};
  rx_stage_e          rx_stage    = RX_TYPE;
  logic [7:0]         pkt_sum     = 8'h00;
  logic [7:0]         pkt_type    = 8'h00;
  logic [7:0]         pkt_id      = 8'h00;
  logic [31:0]        pkt_payload = 32'h0;
  logic [2:0]         pkt_count   = 3'd0;
  logic [2:0]         pkt_len     = 3'd0;
  logic               pkt_crit    = 1'b0;
  logic               pkt_builtin = 1'b0;
  logic               pkt_dup     = 1'b0;

  // Results still owed by the block, oldest first.
  rx_result_t pending_results [$];
  rx_result_t blank_result = '{tpr_pkg::ST_OK, 8'h00, 8'h00, 32'h0, 3'd0};

  int  mismatches    = 0;
  int  bytes_fed     = 0;
  int  cfg_writes    = 0;
  int  burst_left    = 0;
  int  status_seen [7] = '{default: 0};
  int  rx_cycle      = 0;
  bit  random_started = 1'b0;
  logic hold_off     = 1'b0;

  typed_packet_receiver_core #(
    .NUM_TYPES  (NUM_TYPES),
    .ID_SLOTS   (ID_SLOTS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .status_o     (status_o),
    .type_id_o    (type_id_o),
    .packet_id_o  (packet_id_o),
    .payload_o    (payload_o),
    .payload_len_o(payload_len_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  function automatic logic [tpr_pkg::ENTRY_W-1:0] make_entry(input logic en,
                                                             input logic crit,
                                                             input logic [2:0] len,
                                                             input logic [7:0] id);
    return {en, crit, len, id};
  endfunction

  function automatic rx_result_t make_result(input tpr_pkg::status_e st,
                                             input logic [7:0] tid,
                                             input logic [7:0] pid, input logic [31:0] pl,
                                             input logic [2:0] len);
    rx_result_t r;
    r.status      = st;
    r.type_id     = tid;
    r.packet_id   = pid;
    r.payload     = pl;
    r.payload_len = len;
    return r;
  endfunction

  // Table lookup for a non built-in type byte. Scanning from the top down lets
  // the lowest-numbered enabled match overwrite any higher one.
  function automatic bit find_type(input logic [7:0] b, output logic [2:0] len,
                                   output logic crit);
    logic [2:0] raw;
    bit         hit;
    hit  = 1'b0;
    len  = 3'd0;
    crit = 1'b0;
    for (int i = NUM_TYPES - 1; i >= 0; i--) begin
      if (type_table[i][tpr_pkg::ENT_EN_BIT] &&
          type_table[i][tpr_pkg::ENT_ID_LSB +: 8] == b) begin
        raw  = type_table[i][tpr_pkg::ENT_LEN_LSB +: 3];
        len  = (raw > 3'(MAX_PAYLOAD)) ? 3'(MAX_PAYLOAD) : raw;
        crit = type_table[i][tpr_pkg::ENT_CRIT_BIT];
        hit  = 1'b1;
      end
    end
    return hit;
  endfunction

  // Ends the current packet: the status follows from the built-in flag, the
  // duplicate flag and the byte sum, in that order of precedence.
  task automatic close_packet(output rx_result_t r);
    tpr_pkg::status_e st;
    logic [7:0]       id;
    id = pkt_crit ? pkt_id : 8'h00;
    if (pkt_builtin) begin
      if (pkt_sum != tpr_pkg::SUM_GOOD) begin
        st = tpr_pkg::ST_BADSUM;
      end else if (pkt_type == tpr_pkg::TYPE_CONNECT) begin
        st = tpr_pkg::ST_CONNECT;
        seen_ids = '{default: 8'h00};
      end else begin
        st = tpr_pkg::ST_CONNACK;
      end
    end else if (pkt_dup) begin
      st = tpr_pkg::ST_DUP;
    end else if (pkt_sum != tpr_pkg::SUM_GOOD) begin
      st = tpr_pkg::ST_BADSUM;
    end else begin
      st = tpr_pkg::ST_OK;
      if (pkt_crit) seen_ids[pkt_id % ID_SLOTS] = pkt_id;
    end
    r = make_result(st, pkt_type, id, pkt_payload, pkt_count);
    rx_stage = RX_TYPE;
  endtask

  // Advances the packet predictor by one accepted byte.
  task automatic predict_byte(input logic [7:0] b, output bit produced, output rx_result_t r);
    logic [2:0] len;
    logic       crit;
    produced = 1'b0;
    r = blank_result;
    case (rx_stage)
      RX_TYPE: begin
        pkt_payload = 32'h0;
        pkt_count   = 3'd0;
        pkt_id      = 8'h00;
        pkt_dup     = 1'b0;
        pkt_sum     = b;
        pkt_type    = b;
        if (b == tpr_pkg::TYPE_ACK) begin
          r = make_result(tpr_pkg::ST_ACK, b, 8'h00, 32'h0, 3'd0);
          produced = 1'b1;
        end else if (b == tpr_pkg::TYPE_CONNECT || b == tpr_pkg::TYPE_CONNACK) begin
          pkt_builtin = 1'b1;
          pkt_crit    = 1'b0;
          pkt_len     = 3'(tpr_pkg::BUILTIN_LEN);
          rx_stage    = RX_SUM;
        end else if (find_type(b, len, crit)) begin
          pkt_builtin = 1'b0;
          pkt_crit    = crit;
          pkt_len     = len;
          rx_stage    = RX_SUM;
        end else begin
          r = make_result(tpr_pkg::ST_UNKNOWN, b, 8'h00, 32'h0, 3'd0);
          produced = 1'b1;
        end
      end
      RX_SUM: begin
        pkt_sum = pkt_sum + b;
        if (pkt_crit) begin
          rx_stage = RX_ID;
        end else if (pkt_len == 3'd0) begin
          close_packet(r);
          produced = 1'b1;
        end else begin
          rx_stage = RX_DATA;
        end
      end
      RX_ID: begin
        pkt_sum = pkt_sum + b;
        pkt_id  = b;
        pkt_dup = (seen_ids[b % ID_SLOTS] == b);
        if (pkt_len == 3'd0) begin
          close_packet(r);
          produced = 1'b1;
        end else begin
          rx_stage = RX_DATA;
        end
      end
      default: begin
        pkt_sum = pkt_sum + b;
        if (pkt_count < 3'd4) pkt_payload = pkt_payload | (32'(b) << (8 * pkt_count));
        pkt_count = pkt_count + 3'd1;
        if (pkt_count >= pkt_len) begin
          close_packet(r);
          produced = 1'b1;
        end
      end
    endcase
  endtask

  // Offers one byte, waits for the request to be taken and records what it is
  // expected to cause. The result is queued in the step of acceptance, well
  // before the block can present it. Between bursts the sender goes quiet.
  task automatic feed_byte(input logic [7:0] b, input bit typed, input rx_result_t typed_res);
    bit         produced;
    rx_result_t r;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    predict_byte(b, produced, r);
    if (typed) pending_results.push_back(typed_res);
    else if (produced) pending_results.push_back(r);
    bytes_fed++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // One register write request; the caller lowers the valid after its last one.
  task automatic write_type_entry(input logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tpr_pkg::ENTRY_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_TYPES) type_table[idx] = val;
    cfg_writes++;
  endtask

  // Brings the block to rest: no request pending, every result delivered and
  // enough extra cycles for bytes that finish nothing to clear the pipeline.
  task automatic wait_idle();
    if (rx_valid_i) rx_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register setting for a random phase: the first two are the extremes
  // (everything disabled, then every bit set), later ones mix small type ids
  // so that entries often shadow each other.
  task automatic load_setting(input int phase_no);
    logic [tpr_pkg::ENTRY_W-1:0] val;
    logic [7:0]                  id;
    for (int i = 0; i < NUM_TYPES; i++) begin
      case ($urandom_range(0, 3))
        0:       id = 8'hFF;
        1:       id = 8'($urandom);
        default: id = 8'h10 + 8'($urandom_range(0, 3));
      endcase
      if (phase_no == 0) val = '0;
      else if (phase_no == 1) val = '1;
      else if ($urandom_range(0, 3) == 0) val = tpr_pkg::ENTRY_W'($urandom);
      else val = make_entry($urandom_range(0, 7) != 0, 1'($urandom), 3'($urandom), id);
      write_type_entry(tpr_pkg::CFG_IDX_W'(i), val);
    end
    repeat ($urandom_range(1, 3))
      write_type_entry(tpr_pkg::CFG_IDX_W'($urandom_range(NUM_TYPES, 15)),
                       tpr_pkg::ENTRY_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one random packet. Most are well formed with random content; some
  // carry a bad checksum, some are cut short, and some bytes are pure noise.
  // While the predictor sits inside a packet, single bytes finish it first.
  task automatic send_random_packet();
    int         pick;
    int         cut;
    logic [7:0] t;
    logic [7:0] acc;
    logic [7:0] body [$];
    logic [2:0] len;
    logic       crit;
    if (rx_stage != RX_TYPE) begin
      feed_byte(8'($urandom), 1'b0, blank_result);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      feed_byte(8'($urandom), 1'b0, blank_result);
      return;
    end else if (pick < 13) begin
      t = tpr_pkg::TYPE_ACK;
    end else if (pick < 20) begin
      // Look for a byte that is neither built in nor in the table.
      t = 8'($urandom);
      for (int k = 0; k < 8; k++) begin
        if (t > tpr_pkg::TYPE_ACK && !find_type(t, len, crit)) break;
        t = 8'($urandom);
      end
    end else if (pick < 27) begin
      t = tpr_pkg::TYPE_CONNECT;
    end else if (pick < 34) begin
      t = tpr_pkg::TYPE_CONNACK;
    end else begin
      t = type_table[$urandom_range(0, NUM_TYPES - 1)][tpr_pkg::ENT_ID_LSB +: 8];
    end
    if (t == tpr_pkg::TYPE_CONNECT || t == tpr_pkg::TYPE_CONNACK) begin
      len  = 3'(tpr_pkg::BUILTIN_LEN);
      crit = 1'b0;
    end else if (t == tpr_pkg::TYPE_ACK || !find_type(t, len, crit)) begin
      feed_byte(t, 1'b0, blank_result);
      return;
    end
    body.push_back(t);
    body.push_back(8'h00);
    if (crit) body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 15)));
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       body.push_back(8'h00);
        1:       body.push_back(8'hFF);
        default: body.push_back(8'($urandom));
      endcase
    end
    acc = 8'h00;
    foreach (body[k]) acc = acc + body[k];
    body[1] = tpr_pkg::SUM_GOOD - acc;
    if ($urandom_range(0, 7) == 0) body[1] = body[1] + 8'($urandom_range(1, 255));
    cut = body.size();
    if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, body.size() - 1);
    for (int k = 0; k < cut; k++) feed_byte(body[k], 1'b0, blank_result);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: every taken result is compared with the oldest expectation.
  // The ready line follows its own schedule, cycling through always ready, a fixed
  // stall pattern and two random densities; the long hold-off below overrides it.
  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    logic       ready_now;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d type %02h",
                 $time, status_o, type_id_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("type_id", 32'(want.type_id), 32'(type_id_o));
        check_field("packet_id", 32'(want.packet_id), 32'(packet_id_o));
        check_field("payload", want.payload, payload_o);
        check_field("payload_len", 32'(want.payload_len), 32'(payload_len_o));
        if (status_o < 3'd7) status_seen[status_o]++;
      end
    end
    rx_cycle++;
    case (rx_cycle[9:8])
      2'd0:    ready_now = 1'b1;
      2'd1:    ready_now = (rx_cycle % 5) > 1;
      2'd2:    ready_now = $urandom_range(0, 3) != 0;
      default: ready_now = 1'($urandom);
    endcase
    res_ready_i <= rst_ni && !hold_off && ready_now;
  end

  // Long receiver hold-off early in the random traffic, while the sender keeps
  // making requests: the output register and the queue fill up and the block
  // must stall its input without losing or reordering anything.
  initial begin : receiver_hold
    wait (random_started);
    repeat (40) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    directed_row_t row;
    rx_result_t    typed_res;
    int            results_total;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register setting for the directed part, plus two writes outside the
    // table that must leave it untouched.
    write_type_entry(TYPE_ENTRY_0, make_entry(1'b0, 1'b1, 3'd4, 8'hFF));
    write_type_entry(TYPE_ENTRY_1, make_entry(1'b1, 1'b0, 3'd0, 8'h10));
    write_type_entry(TYPE_ENTRY_2, make_entry(1'b1, 1'b1, 3'd0, 8'h20));
    write_type_entry(TYPE_ENTRY_3, make_entry(1'b1, 1'b1, 3'd7, 8'h30));
    write_type_entry(tpr_pkg::CFG_IDX_W'(NUM_TYPES), make_entry(1'b1, 1'b0, 3'd0, 8'hFF));
    write_type_entry(CFG_IDX_LAST, '1);
    cfg_valid_i <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      typed_res = make_result(row.status, row.type_id, row.packet_id, row.payload,
                              row.payload_len);
      feed_byte(row.rx, row.typed, typed_res);
    end
    wait_idle();

    // Random traffic, one register setting per phase. The block is at rest
    // before every setting change.
    random_started = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_setting(p);
      bytes_fed = (p == 0) ? bytes_fed : bytes_fed;
      begin : phase_traffic
        int start_count;
        start_count = bytes_fed;
        while (bytes_fed - start_count < PHASE_BYTES) send_random_packet();
      end
      wait_idle();
    end

    results_total = 0;
    foreach (status_seen[k]) results_total += status_seen[k];
    $display("Run covered %0d bytes, %0d register writes and %0d checked results.",
             bytes_fed, cfg_writes, results_total);
    $display("By status: ok %0d, connect %0d, connack %0d, ack %0d, unknown %0d, %s %0d, %s %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], "bad sum", status_seen[5], "duplicate", status_seen[6]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
